FILE: hw/rtl/fccw_pkg.sv
// shared types and constants of the fat12 cluster chain walker
package fccw_pkg;

	// field widths
	localparam int KIND_W    = 2;
	localparam int INDEX_W   = 13;
	localparam int BYTE_W    = 8;
	localparam int CLUSTER_W = 12;
	localparam int SIZE_W    = 24;
	localparam int SECTOR_W  = 17;
	localparam int COUNT_W   = 10;
	localparam int DSTART_W  = 16;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd2;

	// fat12 constants
	localparam logic [CLUSTER_W-1:0] END_MARK           = 12'hFF8;
	localparam logic [CLUSTER_W-1:0] CLUSTER_NONE       = 12'hFFF;
	localparam logic [SECTOR_W-1:0]  FIRST_DATA_CLUSTER = 17'd2;
	localparam logic [DSTART_W-1:0]  DSTART_RESET       = 16'd33;

	// commands from controller to datapath
	typedef struct packed {
		logic take_load;
		logic take_start;
		logic take_next;
		logic rd_lo;
		logic fin;
	} cmd_t;

endpackage

FILE: hw/rtl/fccw_chan_if.sv
// valid/ready channel interfaces for input and result words

interface fccw_in_if;
	logic                             valid;
	logic                             ready;
	logic [fccw_pkg::KIND_W-1:0]      kind;
	logic [fccw_pkg::INDEX_W-1:0]     table_index;
	logic [fccw_pkg::BYTE_W-1:0]      table_byte;
	logic [fccw_pkg::CLUSTER_W-1:0]   start_cluster;
	logic [fccw_pkg::SIZE_W-1:0]      file_bytes;

	modport source (
		output valid, kind, table_index, table_byte, start_cluster, file_bytes,
		input  ready
	);
	modport sink (
		input  valid, kind, table_index, table_byte, start_cluster, file_bytes,
		output ready
	);
endinterface

interface fccw_out_if;
	logic                           valid;
	logic                           ready;
	logic [fccw_pkg::SECTOR_W-1:0]  sector_number;
	logic [fccw_pkg::COUNT_W-1:0]   byte_count;
	logic                           last_sector;
	logic                           status;

	modport source (
		output valid, sector_number, byte_count, last_sector, status,
		input  ready
	);
	modport sink (
		input  valid, sector_number, byte_count, last_sector, status,
		output ready
	);
endinterface

FILE: hw/rtl/fccw_ram.sv
// generic single write port ram with registered read
module fccw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/fccw_ctrl.sv
// sequencing state machine and handshake control of the chain walker
module fccw_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [fccw_pkg::KIND_W-1:0] in_kind,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output fccw_pkg::cmd_t              cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD1  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;
	logic       fin_done;

	// handshake decode
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_FIN) && out_free);
	assign accept   = in_valid && in_ready;
	assign fin_done = (state_q == ST_FIN) && out_free;

	// commands to the datapath
	always_comb begin
		cmd.take_load  = accept && (in_kind == fccw_pkg::KIND_LOAD);
		cmd.take_start = accept && (in_kind == fccw_pkg::KIND_START);
		cmd.take_next  = accept && (in_kind == fccw_pkg::KIND_NEXT);
		cmd.rd_lo      = (state_q == ST_RD1);
		cmd.fin        = fin_done;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.take_next) begin
					state_nx = ST_RD1;
				end
			end
			ST_RD1: begin
				state_nx = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					state_nx = cmd.take_next ? ST_RD1 : ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (fin_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/fccw_dpath.sv
// table memory, walk state, entry unpacking and output word register
module fccw_dpath #(
	parameter int TABLE_BYTES  = 8192,
	parameter int SECTOR_BYTES = 512
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [fccw_pkg::DSTART_W-1:0]    cfg_wr_data,
	input  fccw_pkg::cmd_t                   cmd,
	input  logic [fccw_pkg::INDEX_W-1:0]     table_index,
	input  logic [fccw_pkg::BYTE_W-1:0]      table_byte,
	input  logic [fccw_pkg::CLUSTER_W-1:0]   start_cluster,
	input  logic [fccw_pkg::SIZE_W-1:0]      file_bytes,
	output logic [fccw_pkg::SECTOR_W-1:0]    sector_number,
	output logic [fccw_pkg::COUNT_W-1:0]     byte_count,
	output logic                             last_sector,
	output logic                             status
);

	localparam int ADDR_W = $clog2(TABLE_BYTES);
	localparam int CNT_W  = $clog2(SECTOR_BYTES + 1);
	localparam int POS_W  = fccw_pkg::INDEX_W;

	logic [fccw_pkg::DSTART_W-1:0]  data_start_q;
	logic [fccw_pkg::CLUSTER_W-1:0] cluster_q;
	logic [fccw_pkg::SIZE_W-1:0]    bytes_left_q;
	logic [POS_W-1:0]               pos_q;
	logic [CNT_W-1:0]               count_q;
	logic                           idle_q;
	logic [fccw_pkg::BYTE_W-1:0]    lo_q;
	logic                           lo_oob_q;

	logic [fccw_pkg::CLUSTER_W-1:0] cur_cluster;
	logic                           active_cur;
	logic [POS_W:0]                 triple;
	logic [POS_W-1:0]               pos_cur;
	logic [POS_W-1:0]               pos_inc;
	logic [CNT_W-1:0]               count_cur;
	logic                           hi_oob;
	logic [fccw_pkg::BYTE_W-1:0]    lo_eff;
	logic [fccw_pkg::BYTE_W-1:0]    hi_eff;
	logic [fccw_pkg::CLUSTER_W-1:0] entry;
	logic [fccw_pkg::SECTOR_W-1:0]  sector_cur;

	logic                           ram_we;
	logic [ADDR_W-1:0]              ram_raddr;
	logic [fccw_pkg::BYTE_W-1:0]    ram_rdata;

	// table byte store
	assign ram_we = cmd.take_load && ({1'b0, table_index} < (POS_W + 1)'(TABLE_BYTES));

	fccw_ram #(
		.WIDTH (fccw_pkg::BYTE_W),
		.DEPTH (TABLE_BYTES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (table_index[ADDR_W-1:0]),
		.wdata (table_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// fat entry unpacking from the two table bytes, out of range reads as zero
	assign hi_oob = ({1'b0, pos_inc} >= (POS_W + 1)'(TABLE_BYTES));
	assign lo_eff = lo_oob_q ? '0 : lo_q;
	assign hi_eff = hi_oob ? '0 : ram_rdata;
	assign entry  = cluster_q[0] ? {hi_eff, lo_eff[7:4]} : {hi_eff[3:0], lo_eff};

	// cluster as seen by an item accepted now, bypassing the finishing update
	assign cur_cluster = (cmd.fin && !idle_q) ? entry : cluster_q;
	assign active_cur  = (cur_cluster < fccw_pkg::END_MARK) && (bytes_left_q != '0);

	// table byte position 3n/2
	assign triple  = {2'b00, cur_cluster} + {1'b0, cur_cluster, 1'b0};
	assign pos_cur = triple[POS_W:1];
	assign pos_inc = pos_q + 1'b1;

	// first byte read on acceptance, second byte on the following cycle
	assign ram_raddr = cmd.take_next ? pos_cur[ADDR_W-1:0] : pos_inc[ADDR_W-1:0];

	// sector bytes taken from the file
	assign count_cur = (bytes_left_q < fccw_pkg::SIZE_W'(SECTOR_BYTES))
		? bytes_left_q[CNT_W-1:0] : CNT_W'(SECTOR_BYTES);

	// sector of the cluster being delivered, modulo 2^17
	assign sector_cur = {1'b0, data_start_q} + {5'b00000, cluster_q}
		- fccw_pkg::FIRST_DATA_CLUSTER;

	// walk state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= fccw_pkg::DSTART_RESET;
			cluster_q    <= fccw_pkg::CLUSTER_NONE;
			bytes_left_q <= '0;
			idle_q       <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				data_start_q <= cfg_wr_data;
			end
			if (cmd.fin && !idle_q) begin
				cluster_q <= entry;
			end
			if (cmd.take_next) begin
				idle_q <= !active_cur;
				if (active_cur) begin
					bytes_left_q <= bytes_left_q - fccw_pkg::SIZE_W'(count_cur);
				end
			end
			if (cmd.take_start) begin
				cluster_q    <= start_cluster;
				bytes_left_q <= file_bytes;
			end
		end
	end

	// per item working registers
	always_ff @(posedge clk) begin
		if (cmd.take_next) begin
			pos_q   <= pos_cur;
			count_q <= count_cur;
		end
		if (cmd.rd_lo) begin
			lo_q     <= ram_rdata;
			lo_oob_q <= ({1'b0, pos_q} >= (POS_W + 1)'(TABLE_BYTES));
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (idle_q) begin
				sector_number <= '0;
				byte_count    <= '0;
				last_sector   <= 1'b0;
				status        <= 1'b1;
			end else begin
				sector_number <= sector_cur;
				byte_count    <= fccw_pkg::COUNT_W'(count_q);
				last_sector   <= (bytes_left_q == '0) || (entry >= fccw_pkg::END_MARK);
				status        <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/fat12_cluster_chain_walker_core.sv
// top level of the fat12 cluster chain walker
// Walks a FAT12 cluster chain held in an on-chip table of TABLE_BYTES bytes.
// Load words write one table byte and start words set the first cluster and
// file size. Every next word returns one result word: a sector read request,
// or status 1 when no walk is active. A next word goes from acceptance
// through ST_RD1 and ST_FIN to its result in the output register, as the two
// table bytes of the fat entry are read one after the other through the
// single read port of the table memory; another word is accepted in the cycle
// a result is stored, so a next word is not taken before the previous one is
// stored. The table has no reset and no clearing pass: entries must be
// loaded before a walk reads them. The output register lets a new word be
// accepted while an earlier result waits to be taken.
module fat12_cluster_chain_walker_core #(
	parameter int TABLE_BYTES  = 8192,
	parameter int SECTOR_BYTES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [fccw_pkg::DSTART_W-1:0] cfg_wr_data,
	fccw_in_if.sink                       in_ch,
	fccw_out_if.source                    out_ch
);

	fccw_pkg::cmd_t cmd;

	// controller
	fccw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_kind   (in_ch.kind),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// datapath
	fccw_dpath #(
		.TABLE_BYTES  (TABLE_BYTES),
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.cmd           (cmd),
		.table_index   (in_ch.table_index),
		.table_byte    (in_ch.table_byte),
		.start_cluster (in_ch.start_cluster),
		.file_bytes    (in_ch.file_bytes),
		.sector_number (out_ch.sector_number),
		.byte_count    (out_ch.byte_count),
		.last_sector   (out_ch.last_sector),
		.status        (out_ch.status)
	);

endmodule
